>>> rtl/core/gcld_pkg.sv
package gcld_pkg;

  localparam int unsigned FIELD_COUNT = 7;
  localparam int unsigned FIELD_W     = 3;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned COORD_W     = 9;

  localparam logic [FIELD_W-1:0] FLD_G    = 3'd0;
  localparam logic [FIELD_W-1:0] FLD_X    = 3'd1;
  localparam logic [FIELD_W-1:0] FLD_Y    = 3'd2;
  localparam logic [FIELD_W-1:0] FLD_Z    = 3'd3;
  localparam logic [FIELD_W-1:0] FLD_F    = 3'd4;
  localparam logic [FIELD_W-1:0] FLD_H    = 3'd5;
  localparam logic [FIELD_W-1:0] FLD_T    = 3'd6;
  localparam logic [FIELD_W-1:0] NO_FIELD = 3'd7;

  localparam logic [7:0] CHR_NUL   = 8'd0;
  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  localparam logic [1:0] HOLD_KEEP = 2'd0;
  localparam logic [1:0] HOLD_ON   = 2'd1;
  localparam logic [1:0] HOLD_OFF  = 2'd2;

  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  localparam logic [COORD_W-1:0] X_LIMIT_RESET   = 9'd480;
  localparam logic [COORD_W-1:0] Y_LIMIT_RESET   = 9'd320;
  localparam logic [VALUE_W-1:0] COOL_TIME_RESET = 16'd1000;
  localparam logic [7:0]         PEN_ANGLE_RESET = 8'd40;
  localparam logic [4:0]         STEP_TIME_BASE  = 5'd20;
  localparam logic [VALUE_W-1:0] F_MIN           = 16'd1;
  localparam logic [VALUE_W-1:0] F_MAX           = 16'd10;

  typedef struct packed {
    logic [1:0]         hold_mode;
    logic               set_step_time;
    logic [4:0]         step_time;
    logic               move_pen;
    logic [VALUE_W-1:0] pen_position;
    logic [VALUE_W-1:0] pen_travel_ms;
    logic               cool_pause;
    logic [VALUE_W-1:0] cool_pause_ms;
    logic               move_x;
    logic [COORD_W-1:0] x_target;
    logic               move_y;
    logic [COORD_W-1:0] y_target;
  } result_t;

  function automatic logic [FIELD_W-1:0] letter_field(input logic [7:0] c);
    logic [FIELD_W-1:0] f;
    case (c)
      8'h47:   f = FLD_G;
      8'h58:   f = FLD_X;
      8'h59:   f = FLD_Y;
      8'h5A:   f = FLD_Z;
      8'h46:   f = FLD_F;
      8'h48:   f = FLD_H;
      8'h54:   f = FLD_T;
      default: f = NO_FIELD;
    endcase
    return f;
  endfunction

  function automatic logic [VALUE_W-1:0] abs_diff16(input logic [VALUE_W-1:0] a,
                                                    input logic [VALUE_W-1:0] b);
    logic [VALUE_W-1:0] d;
    d = a - b;
    if (d[VALUE_W-1]) begin
      d = '0 - d;
    end
    return d;
  endfunction

endpackage

>>> rtl/core/gcode_line_command_decoder.sv
// G-code line command decoder.
// Input channel: one received character per request on in_rx_byte (in_valid /
// in_ready). Letters G X Y Z F H T pick a word, digits build its value, and a
// NUL or LF ends the line.
// Result channel: one command request per line that carried G (out_valid /
// out_ready), with hold mode, step time, pen move with travel delay, cooling
// pause and X/Y targets.
// Output: a line end is registered into the result register, or into the skid
// stage while a result waits. Throughput: one character per cycle while
// in_ready is high; all decoding and the line-end update is one pass of logic.
// Stall: a result register plus a one-entry skid stage sit on the output, so
// characters keep flowing while one command waits; in_ready drops only while
// both hold a command.
// Reset (rst_n low, synchronous): no word selected, no words seen, pen angle
// 40, positions and step count 0, cooling off, cool time 1000, X/Y limits 480
// and 320, both output slots empty.
// Configuration: APB writes at byte 0 (x_limit) and 4 (y_limit); both read back.
module gcode_line_command_decoder (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_hold_mode,
  output logic        out_set_step_time,
  output logic [4:0]  out_step_time,
  output logic        out_move_pen,
  output logic [15:0] out_pen_position,
  output logic [15:0] out_pen_travel_ms,
  output logic        out_cool_pause,
  output logic [15:0] out_cool_pause_ms,
  output logic        out_move_x,
  output logic [8:0]  out_x_target,
  output logic        out_move_y,
  output logic [8:0]  out_y_target,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned VW = gcld_pkg::VALUE_W;
  localparam int unsigned CW = gcld_pkg::COORD_W;
  localparam int unsigned FW = gcld_pkg::FIELD_W;
  localparam int unsigned NF = gcld_pkg::FIELD_COUNT;

  logic [CW-1:0] x_limit_r, y_limit_r;

  logic [FW-1:0] cur_field_r, cur_field_nxt;
  logic [VW-1:0] fval_r [NF];
  logic [VW-1:0] fval_nxt [NF];
  logic [NF-1:0] seen_r, seen_nxt;
  logic [7:0]    pen_angle_r, pen_angle_nxt;
  logic [CW-1:0] pos_x_r, pos_x_nxt;
  logic [CW-1:0] pos_y_r, pos_y_nxt;
  logic [VW-1:0] step_count_r, step_count_nxt;
  logic [VW-1:0] oh_limit_r, oh_limit_nxt;
  logic [VW-1:0] cool_time_r, cool_time_nxt;

  gcld_pkg::result_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;

  logic          in_acc, is_end, is_digit, produce;
  logic [FW-1:0] letter;
  logic [VW-1:0] cur_val, acc_val;
  logic [VW-1:0] sc_h, sc_z, sc_x, abs_z, abs_x, abs_y;
  logic          oh_on, x_ok, y_ok;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      gcld_pkg::REG_X_LIMIT: prdata = {{(32-CW){1'b0}}, x_limit_r};
      gcld_pkg::REG_Y_LIMIT: prdata = {{(32-CW){1'b0}}, y_limit_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= gcld_pkg::X_LIMIT_RESET;
      y_limit_r <= gcld_pkg::Y_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        gcld_pkg::REG_X_LIMIT: x_limit_r <= pwdata[CW-1:0];
        gcld_pkg::REG_Y_LIMIT: y_limit_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign is_end   = in_rx_byte inside {gcld_pkg::CHR_NUL, gcld_pkg::CHR_LF};
  assign is_digit = in_rx_byte inside {[gcld_pkg::CHR_ZERO:gcld_pkg::CHR_NINE]};
  assign letter   = gcld_pkg::letter_field(in_rx_byte);
  assign produce  = in_acc && is_end && seen_r[gcld_pkg::FLD_G];

  assign cur_val = (cur_field_r == gcld_pkg::NO_FIELD) ? '0 : fval_r[cur_field_r];
  assign acc_val = (cur_val << 3) + (cur_val << 1)
                 + {{(VW-4){1'b0}}, 4'(in_rx_byte - gcld_pkg::CHR_ZERO)};

  // line-end command evaluation
  always_comb begin
    res           = '0;
    oh_limit_nxt  = oh_limit_r;
    cool_time_nxt = cool_time_r;
    sc_h          = step_count_r;

    if (fval_r[gcld_pkg::FLD_G] == VW'(1)) begin
      res.hold_mode = gcld_pkg::HOLD_ON;
    end else if (fval_r[gcld_pkg::FLD_G] == VW'(2)) begin
      res.hold_mode = gcld_pkg::HOLD_OFF;
    end

    if (seen_r[gcld_pkg::FLD_H]) begin
      oh_limit_nxt  = fval_r[gcld_pkg::FLD_H];
      cool_time_nxt = gcld_pkg::COOL_TIME_RESET;
      sc_h          = '0;
    end
    if (seen_r[gcld_pkg::FLD_T]) begin
      cool_time_nxt = fval_r[gcld_pkg::FLD_T];
    end
    oh_on = (oh_limit_nxt != '0);

    if (seen_r[gcld_pkg::FLD_F]
        && (fval_r[gcld_pkg::FLD_F] inside {[gcld_pkg::F_MIN:gcld_pkg::F_MAX]})) begin
      res.set_step_time = 1'b1;
      res.step_time     = gcld_pkg::STEP_TIME_BASE - fval_r[gcld_pkg::FLD_F][4:0];
    end

    abs_z         = gcld_pkg::abs_diff16({8'd0, pen_angle_r}, fval_r[gcld_pkg::FLD_Z]);
    sc_z          = sc_h;
    pen_angle_nxt = pen_angle_r;
    if (seen_r[gcld_pkg::FLD_Z]) begin
      res.move_pen      = 1'b1;
      res.pen_position  = fval_r[gcld_pkg::FLD_Z];
      res.pen_travel_ms = (abs_z << 4) - abs_z;
      pen_angle_nxt     = fval_r[gcld_pkg::FLD_Z][7:0];
      if (oh_on && sc_h > oh_limit_nxt) begin
        res.cool_pause    = 1'b1;
        res.cool_pause_ms = cool_time_nxt;
        sc_z              = '0;
      end
    end

    x_ok      = seen_r[gcld_pkg::FLD_X] && fval_r[gcld_pkg::FLD_X] <= {{(VW-CW){1'b0}}, x_limit_r};
    abs_x     = gcld_pkg::abs_diff16({{(VW-CW){1'b0}}, pos_x_r}, fval_r[gcld_pkg::FLD_X]);
    sc_x      = sc_z;
    pos_x_nxt = pos_x_r;
    if (x_ok) begin
      if (oh_on) begin
        sc_x = sc_z + abs_x;
      end
      pos_x_nxt    = fval_r[gcld_pkg::FLD_X][CW-1:0];
      res.move_x   = 1'b1;
      res.x_target = fval_r[gcld_pkg::FLD_X][CW-1:0];
    end

    y_ok      = seen_r[gcld_pkg::FLD_Y] && fval_r[gcld_pkg::FLD_Y] <= {{(VW-CW){1'b0}}, y_limit_r};
    abs_y          = gcld_pkg::abs_diff16({{(VW-CW){1'b0}}, pos_y_r}, fval_r[gcld_pkg::FLD_Y]);
    step_count_nxt = sc_x;
    pos_y_nxt      = pos_y_r;
    if (y_ok) begin
      if (oh_on) begin
        step_count_nxt = sc_x + abs_y;
      end
      pos_y_nxt    = fval_r[gcld_pkg::FLD_Y][CW-1:0];
      res.move_y   = 1'b1;
      res.y_target = fval_r[gcld_pkg::FLD_Y][CW-1:0];
    end
  end

  // character parsing
  always_comb begin
    cur_field_nxt = cur_field_r;
    seen_nxt      = seen_r;
    for (int i = 0; i < NF; i++) begin
      fval_nxt[i] = fval_r[i];
    end
    if (in_acc) begin
      if (is_end) begin
        cur_field_nxt = gcld_pkg::NO_FIELD;
        seen_nxt      = '0;
      end else if (letter != gcld_pkg::NO_FIELD) begin
        cur_field_nxt    = letter;
        fval_nxt[letter] = '0;
        seen_nxt[letter] = 1'b1;
      end else if (is_digit && cur_field_r != gcld_pkg::NO_FIELD) begin
        fval_nxt[cur_field_r] = acc_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_field_r  <= gcld_pkg::NO_FIELD;
      seen_r       <= '0;
      pen_angle_r  <= gcld_pkg::PEN_ANGLE_RESET;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      step_count_r <= '0;
      oh_limit_r   <= '0;
      cool_time_r  <= gcld_pkg::COOL_TIME_RESET;
      for (int i = 0; i < NF; i++) begin
        fval_r[i] <= '0;
      end
    end else begin
      cur_field_r <= cur_field_nxt;
      seen_r      <= seen_nxt;
      for (int i = 0; i < NF; i++) begin
        fval_r[i] <= fval_nxt[i];
      end
      if (produce) begin
        pen_angle_r  <= pen_angle_nxt;
        pos_x_r      <= pos_x_nxt;
        pos_y_r      <= pos_y_nxt;
        step_count_r <= step_count_nxt;
        oh_limit_r   <= oh_limit_nxt;
        cool_time_r  <= cool_time_nxt;
      end
    end
  end

  // result register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (produce) begin
        skid_valid_r <= 1'b1;
        skid_r       <= res;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      out_r        <= skid_r;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= produce;
      if (produce) begin
        out_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hold_mode     = out_r.hold_mode;
  assign out_set_step_time = out_r.set_step_time;
  assign out_step_time     = out_r.step_time;
  assign out_move_pen      = out_r.move_pen;
  assign out_pen_position  = out_r.pen_position;
  assign out_pen_travel_ms = out_r.pen_travel_ms;
  assign out_cool_pause    = out_r.cool_pause;
  assign out_cool_pause_ms = out_r.cool_pause_ms;
  assign out_move_x        = out_r.move_x;
  assign out_x_target      = out_r.x_target;
  assign out_move_y        = out_r.move_y;
  assign out_y_target      = out_r.y_target;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a request while the result register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid stage filled without a stalled result");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_end) |=> (cur_field_r == gcld_pkg::NO_FIELD && seen_r == '0))
    else $error("line end did not clear word selection");

  a_no_pen_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_move_pen) |->
      (out_pen_position == '0 && out_pen_travel_ms == '0 && !out_cool_pause))
    else $error("pen fields set without a pen move");

endmodule

>>> sim/gcode_line_command_decoder_checker.sv
module gcode_line_command_decoder_checker
  import gcld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_hold_mode,
  input  logic        out_set_step_time,
  input  logic [4:0]  out_step_time,
  input  logic        out_move_pen,
  input  logic [15:0] out_pen_position,
  input  logic [15:0] out_pen_travel_ms,
  input  logic        out_cool_pause,
  input  logic [15:0] out_cool_pause_ms,
  input  logic        out_move_x,
  input  logic [8:0]  out_x_target,
  input  logic        out_move_y,
  input  logic [8:0]  out_y_target,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,

  output int          mismatches,
  output int          outstanding,
  output int          cmds_checked,
  output int          cool_pauses
);

  logic [FIELD_W-1:0]     sel_word;
  logic [VALUE_W-1:0]     word_val [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] words_seen;
  logic [7:0]             pen_angle;
  logic [VALUE_W-1:0]     pos_x;
  logic [VALUE_W-1:0]     pos_y;
  logic [VALUE_W-1:0]     step_count;
  logic [VALUE_W-1:0]     heat_limit;
  logic [VALUE_W-1:0]     cool_ms;
  logic [COORD_W-1:0]     x_lim;
  logic [COORD_W-1:0]     y_lim;
  result_t                predicted_cmds [$];

  function automatic logic [VALUE_W-1:0] travel(input logic [VALUE_W-1:0] from,
                                                input logic [VALUE_W-1:0] to);
    logic [VALUE_W-1:0] d;
    d = from - to;
    if (d[VALUE_W-1]) begin
      d = ~d + 16'd1;
    end
    return d;
  endfunction

  function automatic logic [FIELD_W-1:0] word_of(input logic [7:0] c);
    case (c)
      "G":     return FLD_G;
      "X":     return FLD_X;
      "Y":     return FLD_Y;
      "Z":     return FLD_Z;
      "F":     return FLD_F;
      "H":     return FLD_H;
      "T":     return FLD_T;
      default: return NO_FIELD;
    endcase
  endfunction

  task automatic decode_char(input logic [7:0] c);
    logic [FIELD_W-1:0]     f;
    logic [FIELD_COUNT-1:0] s;
    logic [VALUE_W-1:0]     v;
    result_t                r;
    f = word_of(c);
    if (c != CHR_NUL && c != CHR_LF) begin
      if (f != NO_FIELD) begin
        sel_word      = f;
        word_val[f]   = '0;
        words_seen[f] = 1'b1;
      end else if (c >= CHR_ZERO && c <= CHR_NINE && sel_word != NO_FIELD) begin
        word_val[sel_word] = word_val[sel_word] * 16'd10 + {8'd0, c - CHR_ZERO};
      end
    end else begin
      s          = words_seen;
      words_seen = '0;
      sel_word   = NO_FIELD;
      if (s[FLD_G]) begin
        r = '0;
        if (word_val[FLD_G] == 16'd1) begin
          r.hold_mode = HOLD_ON;
        end else if (word_val[FLD_G] == 16'd2) begin
          r.hold_mode = HOLD_OFF;
        end
        if (s[FLD_H]) begin
          heat_limit = word_val[FLD_H];
          cool_ms    = COOL_TIME_RESET;
          step_count = '0;
        end
        if (s[FLD_T]) begin
          cool_ms = word_val[FLD_T];
        end
        if (s[FLD_F] && word_val[FLD_F] >= F_MIN && word_val[FLD_F] <= F_MAX) begin
          r.set_step_time = 1'b1;
          r.step_time     = STEP_TIME_BASE - word_val[FLD_F][4:0];
        end
        if (s[FLD_Z]) begin
          v               = word_val[FLD_Z];
          r.move_pen      = 1'b1;
          r.pen_position  = v;
          r.pen_travel_ms = travel({8'd0, pen_angle}, v) * 16'd15;
          pen_angle       = v[7:0];
          if (heat_limit != '0 && step_count > heat_limit) begin
            r.cool_pause    = 1'b1;
            r.cool_pause_ms = cool_ms;
            step_count      = '0;
          end
        end
        if (s[FLD_X] && word_val[FLD_X] <= {7'd0, x_lim}) begin
          v = word_val[FLD_X];
          if (heat_limit != '0) begin
            step_count = step_count + travel(pos_x, v);
          end
          pos_x      = v;
          r.move_x   = 1'b1;
          r.x_target = v[COORD_W-1:0];
        end
        if (s[FLD_Y] && word_val[FLD_Y] <= {7'd0, y_lim}) begin
          v = word_val[FLD_Y];
          if (heat_limit != '0) begin
            step_count = step_count + travel(pos_y, v);
          end
          pos_y      = v;
          r.move_y   = 1'b1;
          r.y_target = v[COORD_W-1:0];
        end
        predicted_cmds.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      sel_word   = NO_FIELD;
      words_seen = '0;
      pen_angle  = PEN_ANGLE_RESET;
      pos_x      = '0;
      pos_y      = '0;
      step_count = '0;
      heat_limit = '0;
      cool_ms    = COOL_TIME_RESET;
      x_lim      = X_LIMIT_RESET;
      y_lim      = Y_LIMIT_RESET;
      for (int i = 0; i < FIELD_COUNT; i++) begin
        word_val[i] = '0;
      end
      predicted_cmds.delete();
      mismatches   = 0;
      cmds_checked = 0;
      cool_pauses  = 0;
    end else begin
      if (out_valid && out_ready) begin
        cmds_checked++;
        if (predicted_cmds.size() == 0) begin
          $display("%0t: command request with no line end pending, expected none, got x=%0d y=%0d",
                   $time, out_x_target, out_y_target);
          mismatches++;
        end else begin
          want = predicted_cmds.pop_front();
          if (want.cool_pause) begin
            cool_pauses++;
          end
          check_field("hold_mode", 16'(want.hold_mode), 16'(out_hold_mode));
          check_field("set_step_time", 16'(want.set_step_time), 16'(out_set_step_time));
          check_field("step_time", 16'(want.step_time), 16'(out_step_time));
          check_field("move_pen", 16'(want.move_pen), 16'(out_move_pen));
          check_field("pen_position", want.pen_position, out_pen_position);
          check_field("pen_travel_ms", want.pen_travel_ms, out_pen_travel_ms);
          check_field("cool_pause", 16'(want.cool_pause), 16'(out_cool_pause));
          check_field("cool_pause_ms", want.cool_pause_ms, out_cool_pause_ms);
          check_field("move_x", 16'(want.move_x), 16'(out_move_x));
          check_field("x_target", 16'(want.x_target), 16'(out_x_target));
          check_field("move_y", 16'(want.move_y), 16'(out_move_y));
          check_field("y_target", 16'(want.y_target), 16'(out_y_target));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_X_LIMIT) begin
          x_lim = pwdata[COORD_W-1:0];
        end else begin
          y_lim = pwdata[COORD_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        decode_char(in_rx_byte);
      end
    end
    outstanding <= predicted_cmds.size();
  end

endmodule

>>> sim/gcode_line_command_decoder_tb.sv
module gcode_line_command_decoder_tb;
  import gcld_pkg::*;

  localparam int CHAR_TARGET = 1950;
  localparam int PHASES      = 6;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_hold_mode;
  logic        out_set_step_time;
  logic [4:0]  out_step_time;
  logic        out_move_pen;
  logic [15:0] out_pen_position;
  logic [15:0] out_pen_travel_ms;
  logic        out_cool_pause;
  logic [15:0] out_cool_pause_ms;
  logic        out_move_x;
  logic [8:0]  out_x_target;
  logic        out_move_y;
  logic [8:0]  out_y_target;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          cmds_checked;
  int          cool_pauses;

  bit          pace_on = 1'b1;
  int          sink_hold = 0;
  int          chars_sent = 0;
  logic [8:0]  x_lim_now = X_LIMIT_RESET;
  logic [8:0]  y_lim_now = Y_LIMIT_RESET;

  gcode_line_command_decoder u_dut (.*);

  gcode_line_command_decoder_checker u_checker (.*);

  always #10 clk = ~clk;

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned rx_wait;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      rx_wait = pace_on ? $urandom_range(0, 8) : 0;
      if (rx_wait != 0) begin
        out_ready <= 1'b0;
        repeat (rx_wait) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && sink_hold == 0);
    end
  end

  function automatic logic [7:0] field_char(input logic [FIELD_W-1:0] fld);
    case (fld)
      FLD_G:   return "G";
      FLD_X:   return "X";
      FLD_Y:   return "Y";
      FLD_Z:   return "Z";
      FLD_F:   return "F";
      FLD_H:   return "H";
      default: return "T";
    endcase
  endfunction

  function automatic int unsigned pick_coord(input logic [8:0] lim);
    case ($urandom_range(0, 7))
      0:       return 32'(lim);
      1:       return int'(lim) + 1;
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 520);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic send_word(input logic [FIELD_W-1:0] fld);
    int unsigned v;
    string       digits;
    send_byte(field_char(fld));
    case (fld)
      FLD_G:   v = $urandom_range(0, 3);
      FLD_X:   v = pick_coord(x_lim_now);
      FLD_Y:   v = pick_coord(y_lim_now);
      FLD_Z:   v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 255);
      FLD_F:   v = $urandom_range(0, 12);
      FLD_H:   v = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1500);
      default: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 19) == 0) begin
      digits = $sformatf("%0d%0d", $urandom_range(0, 99999), $urandom_range(0, 9999));
    end else if ($urandom_range(0, 15) == 0) begin
      digits = "";
    end else begin
      digits = $sformatf("%s%0d", ($urandom_range(0, 7) == 0) ? "0" : "", v);
    end
    send_text(digits);
  endtask

  task automatic send_random_line();
    logic [FIELD_W-1:0] order [FIELD_COUNT];
    logic [FIELD_W-1:0] t;
    int unsigned        j;
    int unsigned        kind;
    bit                 use_word;
    kind = $urandom_range(0, 11);
    if ($urandom_range(0, 5) == 0) begin
      pace_on = ~pace_on;
    end
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int k = 0; k < FIELD_COUNT; k++) begin
        order[k] = k[FIELD_W-1:0];
      end
      for (int k = FIELD_COUNT - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        t        = order[k];
        order[k] = order[j];
        order[j] = t;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      for (int k = 0; k < FIELD_COUNT; k++) begin
        case (order[k])
          FLD_G:        use_word = (kind != 1);
          FLD_X, FLD_Y: use_word = ($urandom_range(0, 1) == 0);
          FLD_Z, FLD_F: use_word = ($urandom_range(0, 2) == 0);
          FLD_H:        use_word = ($urandom_range(0, 9) == 0);
          default:      use_word = ($urandom_range(0, 5) == 0);
        endcase
        if (use_word) begin
          send_word(order[k]);
          if ($urandom_range(0, 3) == 0) begin
            send_byte(($urandom_range(0, 1) == 0) ? 8'h20 : 8'($urandom_range(8'h61, 8'h7a)));
          end
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(FIELD_W'($urandom_range(0, FIELD_COUNT - 1)));
      end
      send_byte(($urandom_range(0, 1) == 0) ? CHR_LF : CHR_NUL);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [8:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {23'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [8:0] xl;
    logic [8:0] yl;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("7G2F10\n");
    send_text("X5 \n");
    send_text("G1Z255X511Y");
    send_byte(CHR_NUL);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            xl = 9'd511;
            yl = 9'd511;
          end
          2: begin
            xl = '0;
            yl = '0;
          end
          3: begin
            xl = 9'($urandom);
            yl = 9'($urandom);
          end
          4: begin
            xl = 9'd511;
            yl = '0;
          end
          default: begin
            xl = X_LIMIT_RESET;
            yl = Y_LIMIT_RESET;
          end
        endcase
        cfg_write({REG_X_LIMIT, 2'b00}, xl);
        cfg_write({REG_Y_LIMIT, 2'b00}, yl);
        x_lim_now = xl;
        y_lim_now = yl;
      end
      if (phase == 2) begin
        pace_on   = 1'b0;
        sink_hold = 300;
        while (sink_hold != 0) send_random_line();
      end
      while (chars_sent < (phase + 1) * CHAR_TARGET / PHASES) send_random_line();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters across %0d limit settings, with a long output stall",
             chars_sent, PHASES);
    $display("and full drains between settings; checked %0d commands, %0d with a cooling pause.",
             cmds_checked, cool_pauses);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/gcld_pkg.sv
rtl/core/gcode_line_command_decoder.sv
sim/gcode_line_command_decoder_checker.sv
sim/gcode_line_command_decoder_tb.sv
